// ----- rtl/core/mphp_pkg.sv -----
// Shared types, syntax positions and element tables of the picture header parser.
`timescale 1ns / 1ps
package mphp_pkg;

  typedef logic [5:0] pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  element_id;
    logic [7:0]  element_index;
    logic [21:0] element_value;
    logic        header_done;
    logic [7:0]  next_start_code;
    logic        last_of_item;
  } result_t;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned RES_W = $bits(result_t);

  localparam logic [5:0] ID_SKIP = 6'd63;
  localparam logic [5:0] ID_DONE = 6'd46;

  localparam logic [7:0] CODE_USER = 8'hB2;
  localparam logic [7:0] CODE_EXT  = 8'hB5;

  localparam logic [3:0] EXT_QUANT     = 4'd3;
  localparam logic [3:0] EXT_COPYRIGHT = 4'd4;
  localparam logic [3:0] EXT_DISPLAY   = 4'd7;
  localparam logic [3:0] EXT_CODING    = 4'd8;
  localparam logic [3:0] EXT_SPATIAL   = 4'd9;
  localparam logic [3:0] EXT_TEMPORAL  = 4'd10;

  localparam pos_t P_TREF      = 6'd0;
  localparam pos_t P_PCT       = 6'd1;
  localparam pos_t P_VBV       = 6'd2;
  localparam pos_t P_FPF       = 6'd3;
  localparam pos_t P_FFC       = 6'd4;
  localparam pos_t P_FPB       = 6'd5;
  localparam pos_t P_EXTRA_BIT = 6'd7;
  localparam pos_t P_EXTRA_BYTE= 6'd8;
  localparam pos_t P_ALIGN     = 6'd9;
  localparam pos_t P_SEEK      = 6'd10;
  localparam pos_t P_CODE      = 6'd11;
  localparam pos_t P_EXT_ID    = 6'd12;
  localparam pos_t P_FCODE     = 6'd13;
  localparam pos_t P_PSTRUCT   = 6'd15;
  localparam pos_t P_RFF       = 6'd22;
  localparam pos_t P_CDF       = 6'd25;
  localparam pos_t P_VAXIS     = 6'd26;
  localparam pos_t P_PHASE     = 6'd30;
  localparam pos_t P_QM_LOAD   = 6'd31;
  localparam pos_t P_QM_VAL    = 6'd32;
  localparam pos_t P_PD_H      = 6'd33;
  localparam pos_t P_PD_V      = 6'd35;
  localparam pos_t P_PD_M2     = 6'd36;
  localparam pos_t P_SPATIAL   = 6'd37;
  localparam pos_t P_SP_LAST   = 6'd44;
  localparam pos_t P_TEMPORAL  = 6'd45;
  localparam pos_t P_TE_LAST   = 6'd48;
  localparam pos_t P_COPYRIGHT = 6'd49;
  localparam pos_t P_CO_LAST   = 6'd58;
  localparam pos_t P_END       = 6'd59;

  function automatic logic [4:0] pos_width(input pos_t p);
    logic [4:0] w;
    unique case (p)
      6'd0: w = 5'd10;  6'd1: w = 5'd3;   6'd2: w = 5'd16;  6'd3: w = 5'd1;
      6'd4: w = 5'd3;   6'd5: w = 5'd1;   6'd6: w = 5'd3;   6'd7: w = 5'd1;
      6'd8: w = 5'd8;   6'd9: w = 5'd0;   6'd10: w = 5'd8;  6'd11: w = 5'd8;
      6'd12: w = 5'd4;  6'd13: w = 5'd4;  6'd14: w = 5'd2;  6'd15: w = 5'd2;
      6'd27: w = 5'd3;  6'd28: w = 5'd1;  6'd29: w = 5'd7;  6'd30: w = 5'd8;
      6'd31: w = 5'd1;  6'd32: w = 5'd8;  6'd33: w = 5'd16; 6'd34: w = 5'd1;
      6'd35: w = 5'd16; 6'd36: w = 5'd1;  6'd37: w = 5'd10; 6'd38: w = 5'd1;
      6'd39: w = 5'd15; 6'd40: w = 5'd1;  6'd41: w = 5'd15; 6'd42: w = 5'd2;
      6'd43: w = 5'd1;  6'd44: w = 5'd1;  6'd45: w = 5'd2;  6'd46: w = 5'd10;
      6'd47: w = 5'd1;  6'd48: w = 5'd10; 6'd49: w = 5'd1;  6'd50: w = 5'd8;
      6'd51: w = 5'd1;  6'd52: w = 5'd7;  6'd53: w = 5'd1;  6'd54: w = 5'd20;
      6'd55: w = 5'd1;  6'd56: w = 5'd22; 6'd57: w = 5'd1;  6'd58: w = 5'd22;
      default: w = (p >= 6'd16 && p <= 6'd26) ? 5'd1 : 5'd0;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] pos_id(input pos_t p);
    logic [5:0] id;
    unique case (p)
      6'd7, 6'd8, 6'd9, 6'd10, 6'd34, 6'd36, 6'd38, 6'd40, 6'd47,
      6'd53, 6'd55, 6'd57: id = ID_SKIP;
      6'd11: id = ID_DONE;
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6: id = p;
      6'd35: id = 6'd29;
      6'd37: id = 6'd30;
      6'd39: id = 6'd31;
      6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46: id = p - 6'd9;
      6'd48, 6'd49, 6'd50, 6'd51, 6'd52: id = p - 6'd10;
      6'd54: id = 6'd43;
      6'd56: id = 6'd44;
      6'd58: id = 6'd45;
      default: id = (p >= 6'd12 && p <= 6'd33) ? p - 6'd5 : ID_SKIP;
    endcase
    return id;
  endfunction

endpackage

// ----- rtl/core/mphp_fifo.sv -----
// Small register queue that decouples the byte intake, the parser and the result side.
`timescale 1ns / 1ps
module mphp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/core/mphp_parser.sv -----
// Bit-level syntax walker of queued bytes: up to one element per cycle, none if full.
`timescale 1ns / 1ps
module mphp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic               in_empty,
  input  mphp_pkg::in_item_t in_item,
  output logic               in_pop,
  input  logic               out_full,
  output logic               out_push,
  output mphp_pkg::result_t  out_item
);
  import mphp_pkg::*;

  typedef enum logic {ST_LOAD, ST_RUN} state_t;

  state_t      state_r, state_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [5:0]  held_r, held_nxt;
  pos_t        pos_r, pos_nxt;
  logic [2:0]  ct_r, ct_nxt;
  logic [7:0]  lc_r, lc_nxt;
  logic [1:0]  zr_r, zr_nxt;
  logic [1:0]  ps_r, ps_nxt;
  logic        rff_r, rff_nxt;
  logic [3:0]  n_r, n_nxt;
  result_t     pend_r, pend_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic        prog_r;

  logic [4:0]  w;
  logic [5:0]  sh;
  logic [31:0] shifted;
  logic [21:0] v;
  logic [5:0]  id;
  logic [7:0]  idx;
  pos_t        nxt_pos;
  logic        emit, done;
  logic [7:0]  lc_inc, lc_add64;
  logic [1:0]  off_cnt;
  pos_t        b_pos;
  logic [31:0] b_buf;
  logic [5:0]  b_held;

  assign w       = pos_width(pos_r);
  assign sh      = held_r - {1'b0, w};
  assign shifted = buf_r >> sh;
  assign v       = shifted[21:0] & ((22'd1 << w) - 22'd1);
  assign lc_inc  = lc_r + 8'd1;
  assign lc_add64 = lc_r + 8'd64;
  assign off_cnt = (prog_r || ps_r == 2'd1 || ps_r == 2'd2) ? 2'd1 :
                   (rff_r ? 2'd3 : 2'd2);
  assign b_pos   = in_item.first_byte ? P_TREF : pos_r;
  assign b_buf   = in_item.first_byte ? 32'd0 : buf_r;
  assign b_held  = in_item.first_byte ? 6'd0 : held_r;

  always_comb begin
    state_nxt    = state_r;
    buf_nxt      = buf_r;
    held_nxt     = held_r;
    pos_nxt      = pos_r;
    ct_nxt       = ct_r;
    lc_nxt       = lc_r;
    zr_nxt       = zr_r;
    ps_nxt       = ps_r;
    rff_nxt      = rff_r;
    n_nxt        = n_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    in_pop       = 1'b0;
    out_push     = 1'b0;
    out_item     = pend_r;
    id           = pos_id(pos_r);
    idx          = 8'd0;
    nxt_pos      = pos_r + 6'd1;
    emit         = 1'b0;
    done         = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (!in_empty) begin
          in_pop = 1'b1;
          if (in_item.first_byte) begin
            pos_nxt = P_TREF;
            ct_nxt  = 3'd0;
            lc_nxt  = 8'd0;
            zr_nxt  = 2'd0;
            ps_nxt  = 2'd3;
            rff_nxt = 1'b0;
            buf_nxt = 32'd0;
            held_nxt = 6'd0;
          end
          if (b_pos != P_END) begin
            buf_nxt   = {b_buf[23:0], in_item.data_byte};
            held_nxt  = b_held + 6'd8;
            n_nxt     = 4'd0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!out_full) begin
          if (pos_r == P_END || (pos_r != P_ALIGN && held_r < {1'b0, w})) begin
            // Byte exhausted: the held result is the last one of this byte.
            out_push            = pend_vld_r;
            out_item.last_of_item = 1'b1;
            pend_vld_nxt        = 1'b0;
            state_nxt           = ST_LOAD;
          end else if (pos_r == P_ALIGN) begin
            held_nxt = {held_r[5:3], 3'b000};
            zr_nxt   = 2'd0;
            pos_nxt  = P_SEEK;
          end else begin
            held_nxt = sh;
            emit     = (id != ID_SKIP);
            unique case (pos_r)
              P_PCT: ct_nxt = v[2:0];
              P_VBV: nxt_pos = (ct_r == 3'd2 || ct_r == 3'd3) ? P_FPF : P_EXTRA_BIT;
              P_FFC: nxt_pos = (ct_r == 3'd3) ? P_FPB : P_EXTRA_BIT;
              P_EXTRA_BIT: nxt_pos = v[0] ? P_EXTRA_BYTE : P_ALIGN;
              P_EXTRA_BYTE: nxt_pos = P_EXTRA_BIT;
              P_SEEK: begin
                nxt_pos = P_SEEK;
                if (v[7:0] == 8'd0) begin
                  if (zr_r != 2'd2) zr_nxt = zr_r + 2'd1;
                end else if (v[7:0] == 8'd1 && zr_r == 2'd2) begin
                  zr_nxt  = 2'd0;
                  nxt_pos = P_CODE;
                end else begin
                  zr_nxt = 2'd0;
                end
              end
              P_CODE: begin
                emit = 1'b0;
                if (v[7:0] == CODE_USER) begin
                  nxt_pos = P_SEEK;
                end else if (v[7:0] == CODE_EXT) begin
                  nxt_pos = P_EXT_ID;
                end else begin
                  done     = 1'b1;
                  nxt_pos  = P_END;
                  buf_nxt  = 32'd0;
                  held_nxt = 6'd0;
                end
              end
              P_EXT_ID: begin
                lc_nxt = 8'd0;
                unique case (v[3:0])
                  EXT_QUANT:     nxt_pos = P_QM_LOAD;
                  EXT_COPYRIGHT: nxt_pos = P_COPYRIGHT;
                  EXT_DISPLAY:   nxt_pos = P_PD_H;
                  EXT_CODING:    nxt_pos = P_FCODE;
                  EXT_SPATIAL:   nxt_pos = P_SPATIAL;
                  EXT_TEMPORAL:  nxt_pos = P_TEMPORAL;
                  default:       nxt_pos = P_ALIGN;
                endcase
              end
              P_FCODE: begin
                idx = lc_r;
                if (lc_inc < 8'd4) begin
                  lc_nxt  = lc_inc;
                  nxt_pos = P_FCODE;
                end else begin
                  lc_nxt = 8'd0;
                end
              end
              P_PSTRUCT: ps_nxt = v[1:0];
              P_RFF: rff_nxt = v[0];
              P_CDF: nxt_pos = v[0] ? P_VAXIS : P_ALIGN;
              P_PHASE, P_SP_LAST, P_TE_LAST, P_CO_LAST: nxt_pos = P_ALIGN;
              P_QM_LOAD: begin
                idx = {6'd0, lc_r[7:6]};
                if (v[0]) begin
                  nxt_pos = P_QM_VAL;
                end else begin
                  lc_nxt  = lc_add64;
                  nxt_pos = (lc_add64 == 8'd0) ? P_ALIGN : P_QM_LOAD;
                end
              end
              P_QM_VAL: begin
                idx    = lc_r;
                lc_nxt = lc_inc;
                if (lc_inc[5:0] != 6'd0) nxt_pos = P_QM_VAL;
                else nxt_pos = (lc_inc == 8'd0) ? P_ALIGN : P_QM_LOAD;
              end
              P_PD_H, P_PD_V: idx = lc_r;
              P_PD_M2: begin
                lc_nxt  = lc_inc;
                nxt_pos = (lc_inc < {6'd0, off_cnt}) ? P_PD_H : P_ALIGN;
              end
              default: ;
            endcase
            pos_nxt = nxt_pos;
            if ((emit || done) && n_r != 4'd8) begin
              // Release the previous element; the new one waits to learn if it is last.
              out_push                   = pend_vld_r;
              out_item.last_of_item      = 1'b0;
              pend_vld_nxt               = 1'b1;
              n_nxt                      = n_r + 4'd1;
              pend_nxt.element_id        = done ? ID_DONE : id;
              pend_nxt.element_index     = done ? 8'd0 : idx;
              pend_nxt.element_value     = done ? 22'd0 : v;
              pend_nxt.header_done       = done;
              pend_nxt.next_start_code   = done ? v[7:0] : 8'd0;
              pend_nxt.last_of_item      = 1'b0;
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      buf_r      <= '0;
      held_r     <= '0;
      pos_r      <= P_TREF;
      ct_r       <= '0;
      lc_r       <= '0;
      zr_r       <= '0;
      ps_r       <= 2'd3;
      rff_r      <= 1'b0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      prog_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      buf_r      <= buf_nxt;
      held_r     <= held_nxt;
      pos_r      <= pos_nxt;
      ct_r       <= ct_nxt;
      lc_r       <= lc_nxt;
      zr_r       <= zr_nxt;
      ps_r       <= ps_nxt;
      rff_r      <= rff_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_valid) begin
        prog_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end
endmodule

// ----- rtl/core/mpeg2_picture_header_parser.sv -----
// Top level of the picture header parser: byte queue, syntax walker and result queue.
`timescale 1ns / 1ps
// Bytes following a picture start code are pushed into an input queue and
// walked bit by bit by the parser, which completes one syntax element, one
// skipped field or one alignment step per cycle. Each byte is loaded, then
// walked through every step that its bits complete, and then closed by a
// step that releases its held element; a full result queue
// stalls the walker. Elements leave through a result queue, one per pop, and
// the last element caused by a byte carries last_of_item. The input queue
// keeps accepting while results wait to be popped, until it is full. A start
// code other than user data or extension ends the header with a done result;
// further bytes are dropped until a byte with first_byte set restarts the parse.
module mpeg2_picture_header_parser #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_element_id,
  output logic [7:0]  out_element_index,
  output logic [21:0] out_element_value,
  output logic        out_header_done,
  output logic [7:0]  out_next_start_code,
  output logic        out_last_of_item
);
  import mphp_pkg::*;

  in_item_t in_w, in_q;
  result_t  res_w, res_q;
  logic     in_empty, in_pop, out_full, out_push;

  assign cfg_ready = 1'b1;
  assign in_w.data_byte  = in_data_byte;
  assign in_w.first_byte = in_first_byte;

  mphp_fifo #(.WIDTH(IN_W), .DEPTH(IN_DEPTH)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(in_w), .full(full),
    .pop(in_pop), .rdata(in_q), .empty(in_empty)
  );

  mphp_parser u_parser (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .in_empty(in_empty), .in_item(in_q), .in_pop(in_pop),
    .out_full(out_full), .out_push(out_push), .out_item(res_w)
  );

  mphp_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(out_push), .wdata(res_w), .full(out_full),
    .pop(pop), .rdata(res_q), .empty(empty)
  );

  assign out_element_id      = res_q.element_id;
  assign out_element_index   = res_q.element_index;
  assign out_element_value   = res_q.element_value;
  assign out_header_done     = res_q.header_done;
  assign out_next_start_code = res_q.next_start_code;
  assign out_last_of_item    = res_q.last_of_item;
endmodule

// ----- tb/mphp_checker.sv -----
// Checker for the picture header parser: predicts every element from the accepted bytes.
`timescale 1ns / 1ps
module mphp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [5:0]  out_element_id,
  input  logic [7:0]  out_element_index,
  input  logic [21:0] out_element_value,
  input  logic        out_header_done,
  input  logic [7:0]  out_next_start_code,
  input  logic        out_last_of_item,
  output int          fail_count,
  output int          pending
);
  import mphp_pkg::*;

  localparam int MAX_PER_BYTE = 8;

  logic [4:0] width_of [0:58];
  logic [5:0] elem_of  [0:58];

  // Parser state as the block keeps it.
  logic [31:0] shreg;
  int unsigned nbits;
  int unsigned pos;
  logic [2:0]  ctype;
  logic [7:0]  loopc;
  int unsigned zrun;
  logic [1:0]  pstruct;
  logic        rff_q;
  logic        prog_seq;

  result_t elements_due[$];
  int      shown;

  initial begin
    width_of = '{10, 3, 16, 1, 3, 1, 3, 1, 8, 0, 8, 8, 4,
                 4, 2, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                 1, 3, 1, 7, 8,
                 1, 8,
                 16, 1, 16, 1,
                 10, 1, 15, 1, 15, 2, 1, 1,
                 2, 10, 1, 10,
                 1, 8, 1, 7, 1, 20, 1, 22, 1, 22};
    elem_of = '{0, 1, 2, 3, 4, 5, 6, 63, 63, 63, 63, 46, 7,
                8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
                21, 22, 23, 24, 25,
                26, 27,
                28, 63, 29, 63,
                30, 63, 31, 63, 32, 33, 34, 35,
                36, 37, 63, 38,
                39, 40, 41, 42, 63, 43, 63, 44, 63, 45};
    fail_count = 0;
    shown = 0;
  end

  assign pending = elements_due.size();

  task automatic restart_walk();
    shreg = '0;
    nbits = 0;
    pos = P_TREF;
    ctype = '0;
    loopc = '0;
    zrun = 0;
    pstruct = 2'd3;
    rff_q = 1'b0;
  endtask

  function automatic int unsigned offsets_in_display();
    if (prog_seq || pstruct == 2'd1 || pstruct == 2'd2) return 1;
    return rff_q ? 3 : 2;
  endfunction

  // Walks the syntax as far as the bits held allow and queues the elements.
  task automatic walk_byte(input logic [7:0] b, input logic fb);
    int unsigned w, v, nxt;
    logic [7:0] idx;
    logic [5:0] id;
    result_t r;
    result_t batch[$];
    if (fb) restart_walk();
    if (pos >= P_END) return;
    shreg = {shreg[23:0], b};
    nbits += 8;
    while (pos < P_END) begin
      if (pos == P_ALIGN) begin
        nbits -= nbits & 7;
        zrun = 0;
        pos = P_SEEK;
        continue;
      end
      w = width_of[pos];
      if (nbits < w) break;
      nbits -= w;
      v = (shreg >> nbits) & ((32'd1 << w) - 1);
      nxt = pos + 1;
      idx = '0;
      id = elem_of[pos];
      case (pos)
        P_PCT: ctype = v[2:0];
        P_VBV: nxt = (ctype == 3'd2 || ctype == 3'd3) ? P_FPF : P_EXTRA_BIT;
        P_FFC: nxt = (ctype == 3'd3) ? P_FPB : P_EXTRA_BIT;
        P_EXTRA_BIT: nxt = v ? P_EXTRA_BYTE : P_ALIGN;
        P_EXTRA_BYTE: nxt = P_EXTRA_BIT;
        P_SEEK: begin
          nxt = P_SEEK;
          if (v == 0) begin
            if (zrun < 2) zrun++;
          end else if (v == 1 && zrun == 2) begin
            zrun = 0;
            nxt = P_CODE;
          end else begin
            zrun = 0;
          end
        end
        P_CODE: begin
          id = ID_SKIP;
          if (v[7:0] == CODE_USER) nxt = P_SEEK;
          else if (v[7:0] == CODE_EXT) nxt = P_EXT_ID;
          else begin
            r = '0;
            r.element_id = ID_DONE;
            r.header_done = 1'b1;
            r.next_start_code = v[7:0];
            if (batch.size() < MAX_PER_BYTE) batch.push_back(r);
            pos = P_END;
            shreg = '0;
            nbits = 0;
            break;
          end
        end
        P_EXT_ID: begin
          loopc = '0;
          case (v[3:0])
            EXT_QUANT:     nxt = P_QM_LOAD;
            EXT_COPYRIGHT: nxt = P_COPYRIGHT;
            EXT_DISPLAY:   nxt = P_PD_H;
            EXT_CODING:    nxt = P_FCODE;
            EXT_SPATIAL:   nxt = P_SPATIAL;
            EXT_TEMPORAL:  nxt = P_TEMPORAL;
            default:       nxt = P_ALIGN;
          endcase
        end
        P_FCODE: begin
          idx = loopc;
          loopc = loopc + 8'd1;
          if (loopc < 8'd4) nxt = P_FCODE;
          else loopc = '0;
        end
        P_PSTRUCT: pstruct = v[1:0];
        P_RFF: rff_q = v[0];
        P_CDF: nxt = v ? P_VAXIS : P_ALIGN;
        P_PHASE, P_SP_LAST, P_TE_LAST, P_CO_LAST: nxt = P_ALIGN;
        P_QM_LOAD: begin
          idx = loopc >> 6;
          if (v) nxt = P_QM_VAL;
          else begin
            loopc = loopc + 8'd64;
            nxt = (loopc == 0) ? P_ALIGN : P_QM_LOAD;
          end
        end
        P_QM_VAL: begin
          idx = loopc;
          loopc = loopc + 8'd1;
          if (loopc[5:0] != 0) nxt = P_QM_VAL;
          else nxt = (loopc == 0) ? P_ALIGN : P_QM_LOAD;
        end
        P_PD_H, P_PD_V: idx = loopc;
        P_PD_M2: begin
          loopc = loopc + 8'd1;
          nxt = (loopc < offsets_in_display()) ? P_PD_H : P_ALIGN;
        end
        default: ;
      endcase
      if (id != ID_SKIP && batch.size() < MAX_PER_BYTE) begin
        r = '0;
        r.element_id = id;
        r.element_index = idx;
        r.element_value = v[21:0];
        batch.push_back(r);
      end
      pos = nxt;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_item = 1'b1;
    foreach (batch[i]) elements_due.push_back(batch[i]);
  endtask

  task automatic flag(input string what, input result_t want, input result_t got);
    fail_count++;
    if (shown < 10) begin
      shown++;
      $display("%0t %s: expected id %0d idx %0d val %h done %0d code %h last %0d",
               $realtime, what, want.element_id, want.element_index, want.element_value,
               want.header_done, want.next_start_code, want.last_of_item);
      $display("%0t %s:   actual id %0d idx %0d val %h done %0d code %h last %0d",
               $realtime, what, got.element_id, got.element_index, got.element_value,
               got.header_done, got.next_start_code, got.last_of_item);
    end
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      prog_seq = 1'b0;
      restart_walk();
      elements_due.delete();
    end else begin
      // Results are checked before the byte of this edge is walked.
      if (pop && !empty) begin
        got.element_id = out_element_id;
        got.element_index = out_element_index;
        got.element_value = out_element_value;
        got.header_done = out_header_done;
        got.next_start_code = out_next_start_code;
        got.last_of_item = out_last_of_item;
        if (elements_due.size() == 0) flag("unexpected element", '0, got);
        else begin
          want = elements_due.pop_front();
          if (got !== want) flag("element mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) prog_seq = cfg_data;
      if (push && !full) walk_byte(in_data_byte, in_first_byte);
    end
  end

endmodule

// ----- tb/mpeg2_picture_header_parser_tb.sv -----
// Testbench top of the picture header parser: stimulus, reset, watchdog and verdict.
`timescale 1ns / 1ps
module mpeg2_picture_header_parser_tb;
  import mphp_pkg::*;

  localparam int SETTLE = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 35;
  localparam int CALM_AFTER = 150;

  localparam int K_CODING    = 0;
  localparam int K_DISPLAY   = 1;
  localparam int K_QUANT     = 2;
  localparam int K_SPATIAL   = 3;
  localparam int K_TEMPORAL  = 4;
  localparam int K_COPYRIGHT = 5;
  localparam int K_UNKNOWN   = 6;
  localparam int K_USER      = 7;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid, cfg_ready, cfg_data;
  logic        push, full, empty;
  logic        pop = 1'b0;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic [5:0]  out_element_id;
  logic [7:0]  out_element_index;
  logic [21:0] out_element_value;
  logic        out_header_done;
  logic [7:0]  out_next_start_code;
  logic        out_last_of_item;
  int          fail_count, pending;

  bit          bitq[$];
  logic [7:0]  stream[$];
  int          plan[$];
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          calm = 0;
  bit          prog_now = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mpeg2_picture_header_parser dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full), .in_data_byte(in_data_byte), .in_first_byte(in_first_byte),
    .empty(empty), .pop(pop),
    .out_element_id(out_element_id), .out_element_index(out_element_index),
    .out_element_value(out_element_value), .out_header_done(out_header_done),
    .out_next_start_code(out_next_start_code), .out_last_of_item(out_last_of_item)
  );

  mphp_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full), .in_data_byte(in_data_byte), .in_first_byte(in_first_byte),
    .empty(empty), .pop(pop),
    .out_element_id(out_element_id), .out_element_index(out_element_index),
    .out_element_value(out_element_value), .out_header_done(out_header_done),
    .out_next_start_code(out_next_start_code), .out_last_of_item(out_last_of_item),
    .fail_count(fail_count), .pending(pending)
  );

  // The result side stalls in random bursts until the final stretch.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mpeg2_picture_header_parser_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned field_bits(input int fill, input int w);
    int unsigned mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    if (fill == FILL_ONES) return mask;
    if (fill == FILL_ZEROS) return 0;
    return $urandom & mask;
  endfunction

  task automatic put_bits(input int unsigned val, input int w);
    for (int i = w - 1; i >= 0; i--) bitq.push_back(val[i]);
  endtask

  // Pads to a byte boundary and moves the whole bytes into the stream.
  task automatic pack_bytes(input int fill);
    logic [7:0] b;
    while (bitq.size() % 8 != 0) bitq.push_back(1'(field_bits(fill, 1)));
    while (bitq.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
      stream.push_back(b);
    end
  endtask

  task automatic start_prefix(input logic [7:0] code);
    int stuffing;
    stuffing = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    repeat (stuffing) stream.push_back(8'h00);
    stream.push_back(8'h00);
    stream.push_back(8'h00);
    stream.push_back(8'h01);
    stream.push_back(code);
  endtask

  task automatic add_part(input int kind, input int fill, inout logic [1:0] st,
                          inout logic rff);
    int unsigned v, cnt;
    logic [3:0] odd_ids[] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd11, 4'd12, 4'd15};
    if (kind == K_USER) begin
      start_prefix(CODE_USER);
      repeat ($urandom_range(1, 4)) stream.push_back(8'($urandom_range(2, 255)));
      return;
    end
    start_prefix(CODE_EXT);
    case (kind)
      K_CODING: begin
        put_bits(EXT_CODING, 4);
        put_bits(field_bits(fill, 16), 16);
        put_bits(field_bits(fill, 2), 2);
        st = 2'(field_bits(fill, 2));
        put_bits(st, 2);
        put_bits(field_bits(fill, 6), 6);
        rff = 1'(field_bits(fill, 1));
        put_bits(rff, 1);
        put_bits(field_bits(fill, 2), 2);
        v = field_bits(fill, 1);
        put_bits(v, 1);
        if (v) put_bits(field_bits(fill, 20), 20);
      end
      K_DISPLAY: begin
        put_bits(EXT_DISPLAY, 4);
        cnt = (prog_now || st == 2'd1 || st == 2'd2) ? 1 : (rff ? 3 : 2);
        repeat (cnt) begin
          put_bits(field_bits(fill, 17), 17);
          put_bits(field_bits(fill, 17), 17);
        end
      end
      K_QUANT: begin
        put_bits(EXT_QUANT, 4);
        for (int m = 0; m < 4; m++) begin
          v = (fill == FILL_RANDOM) ? ($urandom_range(0, 9) == 0) : 0;
          put_bits(v, 1);
          if (v) repeat (64) put_bits(field_bits(fill, 8), 8);
        end
      end
      K_SPATIAL: begin
        put_bits(EXT_SPATIAL, 4);
        put_bits(field_bits(fill, 23), 23);
        put_bits(field_bits(fill, 23), 23);
      end
      K_TEMPORAL: begin
        put_bits(EXT_TEMPORAL, 4);
        put_bits(field_bits(fill, 23), 23);
      end
      K_COPYRIGHT: begin
        put_bits(EXT_COPYRIGHT, 4);
        repeat (4) put_bits(field_bits(fill, 21), 21);
      end
      default: begin
        put_bits(odd_ids[$urandom_range(0, 7)], 4);
        pack_bytes(fill);
        repeat ($urandom_range(0, 3)) stream.push_back(8'($urandom_range(2, 255)));
      end
    endcase
    pack_bytes(fill);
  endtask

  // Builds one picture header with the extensions listed in plan.
  task automatic build_header(input int fill);
    logic [2:0] pct;
    logic [1:0] st;
    logic       rff;
    logic [7:0] code;
    int         extras;
    stream.delete();
    bitq.delete();
    st = 2'd3;
    rff = 1'b0;
    put_bits(field_bits(fill, 10), 10);
    pct = 3'((fill == FILL_RANDOM) ? (($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                                   : $urandom_range(1, 3))
                                    : field_bits(fill, 3));
    put_bits(pct, 3);
    put_bits(field_bits(fill, 16), 16);
    if (pct == 3'd2 || pct == 3'd3) put_bits(field_bits(fill, 4), 4);
    if (pct == 3'd3) put_bits(field_bits(fill, 4), 4);
    extras = (fill == FILL_ONES) ? 1 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    repeat (extras) begin
      put_bits(1, 1);
      put_bits(field_bits(fill, 8), 8);
    end
    put_bits(0, 1);
    pack_bytes(fill);
    foreach (plan[i]) add_part(plan[i], fill, st, rff);
    do code = 8'($urandom_range(0, 255)); while (code == CODE_USER || code == CODE_EXT);
    if (fill == FILL_ONES) code = 8'hFF;
    if (fill == FILL_ZEROS) code = 8'h00;
    start_prefix(code);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fb);
    if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= fb;
    do @(posedge clk); while (full);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1;
  endtask

  task automatic send_stream(input int upto);
    for (int i = 0; i < upto; i++) send_byte(stream[i], i == 0);
  endtask

  // Holds the byte side until every element has arrived and the walker is idle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_prog(input logic val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    prog_now = val;
  endtask

  initial begin
    int upto;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    push = 1'b0;
    in_data_byte = '0;
    in_first_byte = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_prog(1'b0);

    // Directed: all ones with the coding extension, then all zeros with a
    // display extension and user data, then bytes after the header has ended.
    plan = '{K_CODING};
    build_header(FILL_ONES);
    send_stream(stream.size());
    plan = '{K_DISPLAY, K_USER};
    build_header(FILL_ZEROS);
    send_stream(stream.size());
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_prog(ph % 2 == 0);
      while (items_sent < (ph + 1) * PHASE_ITEMS + 25) begin
        plan.delete();
        if ($urandom_range(0, 3) != 0) plan.push_back(K_CODING);
        repeat ($urandom_range(0, 3)) plan.push_back($urandom_range(K_DISPLAY, K_USER));
        build_header(FILL_RANDOM);
        // Some headers are cut short and restarted by the next first byte.
        upto = ($urandom_range(0, 7) == 0) ? $urandom_range(1, stream.size())
                                           : stream.size();
        send_stream(upto);
        if ($urandom_range(0, 5) == 0) send_byte(8'($urandom), 1'b0);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("mpeg2_picture_header_parser_tb: PASS");
    end else begin
      $display("mpeg2_picture_header_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
